@@ hw/rtl/ising_lattice_spin_flip_engine_core_assert.svh @@
// ----------------------------------------------------------------------------
// Ising spin-flip engine assertion macros
// Shared property forms for the engine's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ISING_LATTICE_SPIN_FLIP_ENGINE_CORE_ASSERT_SVH
`define ISING_LATTICE_SPIN_FLIP_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define ISLF_ASSERT_NOW(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define ISLF_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/islf_pkg.sv @@
// ----------------------------------------------------------------------------
// Ising spin-flip engine package
// Shared constants, command codes and divider interface types.
// ----------------------------------------------------------------------------
package islf_pkg;

   localparam int MAX_SITES = 65536;
   localparam int MAX_DIM   = 4;
   localparam int ADDR_W    = 16;
   localparam int CNT_W     = 17;   // holds MAX_SITES itself
   localparam int SIDE_W    = 9;
   localparam int DIM_W     = 3;

   localparam logic [2:0] CMD_LOAD    = 3'd0;
   localparam logic [2:0] CMD_RECOMP  = 3'd1;
   localparam logic [2:0] CMD_PROPOSE = 3'd2;
   localparam logic [2:0] CMD_ACCEPT  = 3'd3;
   localparam logic [2:0] CMD_REJECT  = 3'd4;

   localparam logic REG_SIDE = 1'b0;
   localparam logic REG_DIM  = 1'b1;

   typedef struct packed {
      logic                start;
      logic [ADDR_W-1:0]   dividend;
      logic [CNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ADDR_W-1:0]   quot;
      logic [CNT_W-1:0]    rem;
   } div_rsp_type;

endpackage

@@ hw/rtl/islf_spin_ram.sv @@
// ----------------------------------------------------------------------------
// Ising spin store
// Single-port spin bit memory, one bit per site, registered read.
// ----------------------------------------------------------------------------
module islf_spin_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [islf_pkg::ADDR_W-1:0] addr,
   input  logic                        wdata,
   output logic                        rdata
);

   logic mem [islf_pkg::MAX_SITES];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/islf_divider.sv @@
// ----------------------------------------------------------------------------
// Ising engine divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module islf_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  islf_pkg::div_req_type req,
   output islf_pkg::div_rsp_type rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [islf_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [islf_pkg::ADDR_W-1:0] quo_ff, quo_in;
   logic [islf_pkg::CNT_W-1:0]  dvs_ff, dvs_in;
   logic [islf_pkg::CNT_W-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[islf_pkg::CNT_W-2:0], quo_ff[islf_pkg::ADDR_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(islf_pkg::ADDR_W);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (trial >= dvs_ff) begin
            rem_in = trial - dvs_ff;
            quo_in = {quo_ff[islf_pkg::ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[islf_pkg::ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

@@ hw/rtl/ising_lattice_spin_flip_engine_core.sv @@
// ----------------------------------------------------------------------------
// Ising lattice spin-flip engine
// Periodic N-dimensional Ising lattice with load, recompute, propose, accept
// and reject commands, one result word per command word.
// ----------------------------------------------------------------------------
// One command word is taken at a time; req_stall stays high until its result
// word has been placed in the output register, and that step waits while a
// stalled result word still occupies the register. Every command first passes
// the stride state, where one shared multiplier forms the strides side^d and
// checks the configuration unless it is already flagged unusable, then the
// dispatch state. Load runs a 16-step division for site modulo site count,
// waits for its done, writes the spin and loads the result word; propose runs
// that division, a read of the old spin, and per dimension one 16-step
// division for the coordinate plus two neighbour reads; recompute walks every
// site, reading the spin and its lower neighbour in each dimension through the
// single-port spin store. Accept, reject and unknown commands, and any command
// under an unusable configuration, go from dispatch straight to the result
// step. The next word can be taken once the sequencer is back in idle, which it
// enters as the result is loaded. The spin store is not cleared by reset.
// ----------------------------------------------------------------------------
module ising_lattice_spin_flip_engine_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_cmd,
   input  logic [15:0]  req_site,
   input  logic         req_spin_value,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic signed [19:0] rsp_energy,
   output logic signed [17:0] rsp_magnetization,
   output logic [16:0]  rsp_abs_magnetization,
   output logic signed [5:0]  rsp_energy_change,
   output logic         rsp_config_error,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [8:0]   csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_GEO    = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_MODK   = 4'd3;
   localparam logic [3:0] S_PRIOR  = 4'd4;
   localparam logic [3:0] S_PDIV   = 4'd5;
   localparam logic [3:0] S_PLO    = 4'd6;
   localparam logic [3:0] S_PHI    = 4'd7;
   localparam logic [3:0] S_PFIN   = 4'd8;
   localparam logic [3:0] S_RISSUE = 4'd9;
   localparam logic [3:0] S_RSELF  = 4'd10;
   localparam logic [3:0] S_RNB    = 4'd11;
   localparam logic [3:0] S_RSUM   = 4'd12;
   localparam logic [3:0] S_RFIN   = 4'd13;
   localparam logic [3:0] S_RESP   = 4'd14;

   localparam int AW = islf_pkg::ADDR_W;
   localparam int CW = islf_pkg::CNT_W;
   localparam int SW = islf_pkg::SIDE_W;
   localparam int DW = islf_pkg::DIM_W;
   localparam int OFF_N = islf_pkg::MAX_DIM + 1;

   // neighbour address along one dimension with periodic wrap
   function automatic logic [AW-1:0] nb_addr(
      input logic [CW-1:0] base,
      input logic [SW-1:0] coord,
      input logic [SW-1:0] side,
      input logic [CW-1:0] off_lo,
      input logic [CW-1:0] off_hi,
      input logic          lower
   );
      logic [CW:0] span;
      logic [CW:0] sum;
      span = {1'b0, off_hi} - {1'b0, off_lo};
      if (lower) begin
         if (coord == '0) sum = {1'b0, base} + span;
         else             sum = {1'b0, base} - {1'b0, off_lo};
      end else begin
         if (coord == side - 9'd1) sum = {1'b0, base} - span;
         else                      sum = {1'b0, base} + {1'b0, off_lo};
      end
      return sum[AW-1:0];
   endfunction

   // configuration
   logic [SW-1:0] side_ff;
   logic [DW-1:0] dim_ff;

   // sequencer
   logic [3:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [AW-1:0] site_ff, site_in;
   logic          sv_ff, sv_in;
   logic          err_ff, err_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] off_ff [OFF_N];
   logic [CW-1:0] off_in [OFF_N];

   // lattice observables and move record
   logic signed [19:0] energy_ff, energy_in;
   logic signed [17:0] magnet_ff, magnet_in;
   logic signed [19:0] esaved_ff, esaved_in;
   logic signed [17:0] msaved_ff, msaved_in;
   logic [AW-1:0]      flipped_ff, flipped_in;
   logic               prior_ff, prior_in;
   logic signed [5:0]  delta_ff, delta_in;

   // propose working registers
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      q_ff, q_in;
   logic [SW-1:0]      pc_ff, pc_in;
   logic signed [4:0]  nsum_ff, nsum_in;

   // recompute walk
   logic [CW-1:0]      i_ff, i_in;
   logic [SW-1:0]      c_ff [islf_pkg::MAX_DIM];
   logic [SW-1:0]      c_in [islf_pkg::MAX_DIM];
   logic               s_ff, s_in;
   logic signed [3:0]  nacc_ff, nacc_in;
   logic signed [19:0] eacc_ff, eacc_in;
   logic signed [17:0] macc_ff, macc_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [19:0] rsp_energy_ff, rsp_energy_in;
   logic signed [17:0] rsp_magnet_ff, rsp_magnet_in;
   logic [16:0]        rsp_abs_ff, rsp_abs_in;
   logic signed [5:0]  rsp_delta_ff, rsp_delta_in;
   logic               rsp_err_ff, rsp_err_in;

   // shared units
   islf_pkg::div_req_type div_req;
   islf_pkg::div_rsp_type div_rsp;
   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   logic                  mem_wd;
   logic                  mem_rd;

   logic                  req_take;
   logic [CW+SW-1:0]      product;
   logic                  carry;
   logic signed [5:0]     delta_w;
   logic signed [17:0]    mag_neg;
   logic [DW-1:0]         d_next;
   logic                  div_wait_st;
   logic                  mem_wr_st;

   islf_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   islf_spin_ram u_ram (
      .clock (clock),
      .wr_en (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wd),
      .rdata (mem_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign d_next    = d_ff + 3'd1;

   // take a register write; the host must write only while no word is in flight, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 9'd16;
         dim_ff  <= 3'd2;
      end else if (csr_we) begin
         if (csr_index == islf_pkg::REG_SIDE) begin
            side_ff <= csr_wdata;
         end else begin
            dim_ff <= csr_wdata[DW-1:0];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      site_in    = site_ff;
      sv_in      = sv_ff;
      err_in     = err_ff;
      d_in       = d_ff;
      off_in     = off_ff;
      energy_in  = energy_ff;
      magnet_in  = magnet_ff;
      esaved_in  = esaved_ff;
      msaved_in  = msaved_ff;
      flipped_in = flipped_ff;
      prior_in   = prior_ff;
      delta_in   = delta_ff;
      k_in       = k_ff;
      q_in       = q_ff;
      pc_in      = pc_ff;
      nsum_in    = nsum_ff;
      i_in       = i_ff;
      c_in       = c_ff;
      s_in       = s_ff;
      nacc_in    = nacc_ff;
      eacc_in    = eacc_ff;
      macc_in    = macc_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_energy_in = rsp_energy_ff;
      rsp_magnet_in = rsp_magnet_ff;
      rsp_abs_in    = rsp_abs_ff;
      rsp_delta_in  = rsp_delta_ff;
      rsp_err_in    = rsp_err_ff;

      div_req.start    = 1'b0;
      div_req.dividend = site_ff;
      div_req.divisor  = off_ff[dim_ff];
      mem_we   = 1'b0;
      mem_addr = k_ff;
      mem_wd   = 1'b0;

      product = off_ff[d_ff] * side_ff;
      carry   = 1'b1;
      delta_w = prior_ff ? {nsum_ff, 1'b0} : -{nsum_ff, 1'b0};
      mag_neg = -magnet_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_cmd;
               site_in   = req_site;
               sv_in     = req_spin_value;
               d_in      = '0;
               off_in[0] = CW'(1);
               err_in    = (side_ff < 9'd2) || (dim_ff == '0) ||
                           (dim_ff > DW'(islf_pkg::MAX_DIM));
               state_in  = S_GEO;
            end
         end
         S_GEO: begin
            // form side^d one stride per cycle, flag an oversized lattice
            if (err_ff || d_ff == dim_ff) begin
               state_in = S_DISP;
            end else begin
               if (product > (CW+SW)'(islf_pkg::MAX_SITES)) begin
                  err_in = 1'b1;
               end
               off_in[d_next] = product[CW-1:0];
               d_in = d_next;
            end
         end
         S_DISP: begin
            if (err_ff) begin
               state_in = S_RESP;
            end else begin
               case (cmd_ff)
                  islf_pkg::CMD_LOAD, islf_pkg::CMD_PROPOSE: begin
                     div_req.start = 1'b1;
                     state_in = S_MODK;
                  end
                  islf_pkg::CMD_RECOMP: begin
                     i_in    = '0;
                     c_in    = '{default: '0};
                     eacc_in = '0;
                     macc_in = '0;
                     state_in = S_RISSUE;
                  end
                  islf_pkg::CMD_ACCEPT: begin
                     esaved_in = energy_ff;
                     msaved_in = magnet_ff;
                     state_in  = S_RESP;
                  end
                  islf_pkg::CMD_REJECT: begin
                     mem_we    = 1'b1;
                     mem_addr  = flipped_ff;
                     mem_wd    = prior_ff;
                     energy_in = esaved_ff;
                     magnet_in = msaved_ff;
                     state_in  = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_MODK: begin
            mem_addr = div_rsp.rem[AW-1:0];
            if (div_rsp.done) begin
               k_in = div_rsp.rem[AW-1:0];
               if (cmd_ff == islf_pkg::CMD_LOAD) begin
                  mem_we   = 1'b1;
                  mem_wd   = sv_ff;
                  state_in = S_RESP;
               end else begin
                  state_in = S_PRIOR;
               end
            end
         end
         S_PRIOR: begin
            // old spin is on the read port: flip it and save the observables
            prior_in   = mem_rd;
            mem_we     = 1'b1;
            mem_addr   = k_ff;
            mem_wd     = !mem_rd;
            esaved_in  = energy_ff;
            msaved_in  = magnet_ff;
            flipped_in = k_ff;
            nsum_in    = '0;
            d_in       = '0;
            q_in       = k_ff;
            div_req.start    = 1'b1;
            div_req.dividend = k_ff;
            div_req.divisor  = CW'(side_ff);
            state_in = S_PDIV;
         end
         S_PDIV: begin
            mem_addr = nb_addr(CW'(k_ff), div_rsp.rem[SW-1:0], side_ff,
                               off_ff[d_ff], off_ff[d_next], 1'b1);
            if (div_rsp.done) begin
               pc_in    = div_rsp.rem[SW-1:0];
               q_in     = div_rsp.quot;
               state_in = S_PLO;
            end
         end
         S_PLO: begin
            nsum_in  = nsum_ff + (mem_rd ? 5'sd1 : -5'sd1);
            mem_addr = nb_addr(CW'(k_ff), pc_ff, side_ff,
                               off_ff[d_ff], off_ff[d_next], 1'b0);
            state_in = S_PHI;
         end
         S_PHI: begin
            nsum_in = nsum_ff + (mem_rd ? 5'sd1 : -5'sd1);
            d_in    = d_next;
            if (d_next == dim_ff) begin
               state_in = S_PFIN;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = q_ff;
               div_req.divisor  = CW'(side_ff);
               state_in = S_PDIV;
            end
         end
         S_PFIN: begin
            energy_in = energy_ff + 20'(delta_w);
            magnet_in = prior_ff ? magnet_ff - 18'sd2 : magnet_ff + 18'sd2;
            delta_in  = delta_w;
            state_in  = S_RESP;
         end
         S_RISSUE: begin
            mem_addr = i_ff[AW-1:0];
            d_in     = '0;
            nacc_in  = '0;
            state_in = S_RSELF;
         end
         S_RSELF: begin
            s_in     = mem_rd;
            mem_addr = nb_addr(i_ff, c_ff[0], side_ff, off_ff[0], off_ff[1], 1'b1);
            state_in = S_RNB;
         end
         S_RNB: begin
            nacc_in = nacc_ff + (mem_rd ? 4'sd1 : -4'sd1);
            if (d_next < dim_ff) begin
               d_in     = d_next;
               mem_addr = nb_addr(i_ff, c_ff[d_next[1:0]], side_ff,
                                  off_ff[d_next], off_ff[d_next + 3'd1], 1'b1);
            end else begin
               state_in = S_RSUM;
            end
         end
         S_RSUM: begin
            // fold the site's lower bonds, then advance the coordinate odometer
            eacc_in = s_ff ? eacc_ff - 20'(nacc_ff) : eacc_ff + 20'(nacc_ff);
            macc_in = s_ff ? macc_ff + 18'sd1 : macc_ff - 18'sd1;
            i_in    = i_ff + CW'(1);
            for (int d = 0; d < islf_pkg::MAX_DIM; d++) begin
               if (carry && (DW'(d) < dim_ff)) begin
                  if (c_ff[d] == side_ff - 9'd1) begin
                     c_in[d] = '0;
                  end else begin
                     c_in[d] = c_ff[d] + 9'd1;
                     carry   = 1'b0;
                  end
               end
            end
            if (i_ff + CW'(1) == off_ff[dim_ff]) begin
               state_in = S_RFIN;
            end else begin
               state_in = S_RISSUE;
            end
         end
         S_RFIN: begin
            energy_in = eacc_ff;
            magnet_in = macc_ff;
            state_in  = S_RESP;
         end
         S_RESP: begin
            // load the result word once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = energy_ff;
               rsp_magnet_in = magnet_ff;
               rsp_abs_in    = magnet_ff[17] ? mag_neg[16:0] : magnet_ff[16:0];
               rsp_delta_in  = delta_ff;
               rsp_err_in    = err_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         magnet_ff    <= '0;
         esaved_ff    <= '0;
         msaved_ff    <= '0;
         flipped_ff   <= '0;
         prior_ff     <= 1'b0;
         delta_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         magnet_ff    <= magnet_in;
         esaved_ff    <= esaved_in;
         msaved_ff    <= msaved_in;
         flipped_ff   <= flipped_in;
         prior_ff     <= prior_in;
         delta_ff     <= delta_in;
      end
      cmd_ff        <= cmd_in;
      site_ff       <= site_in;
      sv_ff         <= sv_in;
      err_ff        <= err_in;
      d_ff          <= d_in;
      off_ff        <= off_in;
      k_ff          <= k_in;
      q_ff          <= q_in;
      pc_ff         <= pc_in;
      nsum_ff       <= nsum_in;
      i_ff          <= i_in;
      c_ff          <= c_in;
      s_ff          <= s_in;
      nacc_ff       <= nacc_in;
      eacc_ff       <= eacc_in;
      macc_ff       <= macc_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_magnet_ff <= rsp_magnet_in;
      rsp_abs_ff    <= rsp_abs_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_energy            = rsp_energy_ff;
   assign rsp_magnetization     = rsp_magnet_ff;
   assign rsp_abs_magnetization = rsp_abs_ff;
   assign rsp_energy_change     = rsp_delta_ff;
   assign rsp_config_error      = rsp_err_ff;

   // states in which the divider may finish or the spin store may be written
   assign div_wait_st = (state_ff == S_MODK) || (state_ff == S_PDIV);
   assign mem_wr_st   = (state_ff == S_DISP) || (state_ff == S_MODK) ||
                        (state_ff == S_PRIOR);

`include "ising_lattice_spin_flip_engine_core_assert.svh"

   `ISLF_ASSERT_NOW(a_div_done, clock, reset, div_rsp.done, div_wait_st, "stray divider result")
   `ISLF_ASSERT_NOW(a_mem_write, clock, reset, mem_we, mem_wr_st, "spin store write out of step")
   `ISLF_ASSERT_NEXT(a_take_to_geo, clock, reset, req_take, (state_ff == S_GEO), "no stride setup")

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Ising spin-flip engine testbench
// Drives command words into the lattice engine under random idling and a long
// result hold-off, takes each expected word from its table row or predicts it
// from its own copy of the lattice and observables, and compares field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // spare command codes, which the engine must treat as no-ops
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [19:0] energy;
      logic signed [17:0] magnet;
      logic [16:0]        abs_magnet;
      logic signed [5:0]  delta;
      logic               cfg_err;
   } obs_word_type;

   typedef struct {
      bit           is_cfg;
      logic [8:0]   side;
      logic [2:0]   dim;
      logic [2:0]   cmd;
      logic [15:0]  site;
      logic         spin;
      bit           typed;
      obs_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_cmd = islf_pkg::CMD_LOAD;
   logic [15:0] req_site = '0;
   logic req_spin_value = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [19:0] rsp_energy;
   logic signed [17:0] rsp_magnetization;
   logic [16:0] rsp_abs_magnetization;
   logic signed [5:0] rsp_energy_change;
   logic rsp_config_error;
   logic csr_we = 1'b0;
   logic csr_index = islf_pkg::REG_SIDE;
   logic [8:0] csr_wdata = '0;

   ising_lattice_spin_flip_engine_core i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Own copy of the engine state
   // ---------------------------------------------------------------------
   bit                 lattice_q [islf_pkg::MAX_SITES];
   logic signed [19:0] energy_q, energy_keep;
   logic signed [17:0] magnet_q, magnet_keep;
   int                 flip_site_q;
   bit                 prior_spin_q;
   logic signed [5:0]  delta_q;
   int                 side_q, dim_q;

   obs_word_type pending_obs[$];
   stim_row_type table_q[$];
   int           fails = 0;
   int           words_sent = 0;
   int           words_seen = 0;

   // number of sites, zero when the configuration is unusable
   function automatic int lattice_sites();
      int p = 1;
      if (side_q < 2 || dim_q < 1 || dim_q > islf_pkg::MAX_DIM) return 0;
      for (int d = 0; d < dim_q; d++) begin
         p = p * side_q;
         if (p > islf_pkg::MAX_SITES) return 0;
      end
      return p;
   endfunction

   function automatic int spin_of(int idx);
      return lattice_q[idx] ? 1 : -1;
   endfunction

   // sum of the lower neighbours, or of all 2*dim neighbours when both is set
   function automatic int bond_sum(int idx, bit both);
      int off = 1;
      int sum = 0;
      int c, base, lo, hi;
      for (int d = 0; d < dim_q; d++) begin
         c    = (idx / off) % side_q;
         base = idx - c * off;
         lo   = (c == 0) ? side_q - 1 : c - 1;
         hi   = (c == side_q - 1) ? 0 : c + 1;
         sum += spin_of(base + lo * off);
         if (both) sum += spin_of(base + hi * off);
         off = off * side_q;
      end
      return sum;
   endfunction

   function automatic obs_word_type advance_lattice(logic [2:0] cmd, logic [15:0] site,
                                                    logic spin);
      obs_word_type r;
      int total = lattice_sites();
      int k, old, dlt, mi;
      longint e, m;
      if (total != 0) begin
         case (cmd)
            islf_pkg::CMD_LOAD: begin
               lattice_q[int'(site) % total] = spin;
            end
            islf_pkg::CMD_RECOMP: begin
               e = 0;
               m = 0;
               for (int i = 0; i < total; i++) begin
                  e += spin_of(i) * bond_sum(i, 1'b0);
                  m += spin_of(i);
               end
               energy_q = 20'(-e);
               magnet_q = 18'(m);
            end
            islf_pkg::CMD_PROPOSE: begin
               k = int'(site) % total;
               energy_keep  = energy_q;
               magnet_keep  = magnet_q;
               flip_site_q  = k;
               prior_spin_q = lattice_q[k];
               old = prior_spin_q ? 1 : -1;
               lattice_q[k] = ~prior_spin_q;
               dlt = 2 * old * bond_sum(k, 1'b1);
               energy_q = 20'(int'(energy_q) + dlt);
               magnet_q = 18'(int'(magnet_q) - 2 * old);
               delta_q  = 6'(dlt);
            end
            islf_pkg::CMD_ACCEPT: begin
               energy_keep = energy_q;
               magnet_keep = magnet_q;
            end
            islf_pkg::CMD_REJECT: begin
               lattice_q[flip_site_q] = prior_spin_q;
               energy_q = energy_keep;
               magnet_q = magnet_keep;
            end
            default: ;
         endcase
      end
      mi = magnet_q;
      r.energy     = energy_q;
      r.magnet     = magnet_q;
      r.abs_magnet = 17'(mi < 0 ? -mi : mi);
      r.delta      = delta_q;
      r.cfg_err    = (total == 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // no idling on either side while this holds
   function automatic bit quiet_stretch();
      return words_sent >= 250 && words_sent < 340;
   endfunction

   task automatic send_word(logic [2:0] cmd, logic [15:0] site, logic spin,
                            bit typed = 0, obs_word_type want = '0);
      obs_word_type pred;
      int gap;
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_site       <= site;
      req_spin_value <= spin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: predict, then maybe idle
      pred = advance_lattice(cmd, site, spin);
      pending_obs = {pending_obs, (typed ? want : pred)};
      words_sent++;
      if (!quiet_stretch() && $urandom_range(0, 99) < 34) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every result, then write both registers
   task automatic set_lattice(logic [8:0] side, logic [2:0] dim);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_obs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= islf_pkg::REG_SIDE;
      csr_wdata <= side;
      @(posedge clock);
      csr_index <= islf_pkg::REG_DIM;
      csr_wdata <= 9'(dim);
      @(posedge clock);
      csr_we <= 1'b0;
      side_q = side;
      dim_q  = dim;
   endtask

   // load every site so that no read ever touches an unwritten spin
   task automatic fill_lattice();
      int total = lattice_sites();
      for (int i = 0; i < total; i++) begin
         send_word(islf_pkg::CMD_LOAD, 16'(i), 1'($urandom));
      end
   endtask

   // random words; with reads allowed, mostly propose followed by a decision
   task automatic random_words(int count, bit reads_ok);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (!reads_ok && r < 72) r = 50;
         if (r < 45) begin
            send_word(islf_pkg::CMD_PROPOSE, 16'($urandom), 1'($urandom));
            send_word($urandom_range(0, 1) ? islf_pkg::CMD_ACCEPT : islf_pkg::CMD_REJECT,
                      16'($urandom), 1'($urandom));
         end else if (r < 60) begin
            send_word(islf_pkg::CMD_LOAD, 16'($urandom), 1'($urandom));
         end else if (r < 72) begin
            send_word(islf_pkg::CMD_RECOMP, 16'($urandom), 1'($urandom));
         end else if (r < 80) begin
            send_word(islf_pkg::CMD_ACCEPT, 16'($urandom), 1'($urandom));
         end else if (r < 88) begin
            send_word(islf_pkg::CMD_REJECT, 16'($urandom), 1'($urandom));
         end else if (r < 95) begin
            send_word(reads_ok ? islf_pkg::CMD_PROPOSE : islf_pkg::CMD_LOAD,
                      16'($urandom), 1'($urandom));
         end else begin
            send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                      16'($urandom), 1'($urandom));
         end
      end
   endtask

   function automatic stim_row_type cfg_row(logic [8:0] side, logic [2:0] dim);
      stim_row_type s;
      s = '{default: '0};
      s.is_cfg = 1;
      s.side   = side;
      s.dim    = dim;
      return s;
   endfunction

   function automatic stim_row_type cmd_row(logic [2:0] cmd, logic [15:0] site, logic spin,
                                            bit typed = 0, obs_word_type want = '0);
      stim_row_type s;
      s = '{default: '0};
      s.cmd   = cmd;
      s.site  = site;
      s.spin  = spin;
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   // append one row to the stimulus table
   task automatic add_row(stim_row_type row);
      table_q = {table_q, row};
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random stall, one long hold-off to back the engine up
   // ---------------------------------------------------------------------
   int  hold_left = 0;
   bit  held_once = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!held_once && words_seen >= 120) begin
         held_once <= 1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (quiet_stretch()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 34);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      obs_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen <= words_seen + 1;
         if (pending_obs.size() == 0) begin
            $display("%t: result word with none expected", $realtime);
            fails++;
         end else begin
            w = pending_obs.pop_front();
            if (rsp_energy !== w.energy) begin
               $display("%t: energy expected %0d actual %0d", $realtime,
                        w.energy, rsp_energy);
               fails++;
            end
            if (rsp_magnetization !== w.magnet) begin
               $display("%t: magnetization expected %0d actual %0d", $realtime,
                        w.magnet, rsp_magnetization);
               fails++;
            end
            if (rsp_abs_magnetization !== w.abs_magnet) begin
               $display("%t: abs magnetization expected %0d actual %0d", $realtime,
                        w.abs_magnet, rsp_abs_magnetization);
               fails++;
            end
            if (rsp_energy_change !== w.delta) begin
               $display("%t: energy change expected %0d actual %0d", $realtime,
                        w.delta, rsp_energy_change);
               fails++;
            end
            if (rsp_config_error !== w.cfg_err) begin
               $display("%t: config error expected %0b actual %0b", $realtime,
                        w.cfg_err, rsp_config_error);
               fails++;
            end
         end
      end
   end

   // guard against a hung engine
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      obs_word_type zero_obs;
      side_q = 16;
      dim_q  = 2;
      energy_q = '0; energy_keep = '0;
      magnet_q = '0; magnet_keep = '0;
      flip_site_q = 0; prior_spin_q = 0; delta_q = '0;
      zero_obs = '0;

      // right after reset everything reads zero; reject restores site 0 down
      add_row(cmd_row(islf_pkg::CMD_ACCEPT, 16'hFFFF, 1'b1, 1, zero_obs));
      add_row(cmd_row(CMD_SPARE_HI, 16'h0000, 1'b0, 1, zero_obs));
      add_row(cmd_row(islf_pkg::CMD_REJECT, 16'h1234, 1'b1, 1, zero_obs));
      add_row(cmd_row(islf_pkg::CMD_LOAD, 16'hFFFF, 1'b1, 1, zero_obs));
      // smallest lattice: two sites on a ring, both up
      add_row(cfg_row(9'd2, 3'd1));
      add_row(cmd_row(islf_pkg::CMD_LOAD, 16'h0000, 1'b1, 1, zero_obs));
      add_row(cmd_row(islf_pkg::CMD_LOAD, 16'hFFFF, 1'b1, 1, zero_obs));
      add_row(cmd_row(islf_pkg::CMD_RECOMP, 16'h0000, 1'b0, 1,
                      '{-20'sd2, 18'sd2, 17'd2, 6'sd0, 1'b0}));
      add_row(cmd_row(islf_pkg::CMD_PROPOSE, 16'h0000, 1'b0, 1,
                      '{20'sd2, 18'sd0, 17'd0, 6'sd4, 1'b0}));
      add_row(cmd_row(islf_pkg::CMD_REJECT, 16'h0000, 1'b0, 1,
                      '{-20'sd2, 18'sd2, 17'd2, 6'sd4, 1'b0}));
      add_row(cmd_row(islf_pkg::CMD_PROPOSE, 16'hFFFF, 1'b0));
      add_row(cmd_row(islf_pkg::CMD_ACCEPT, 16'h0000, 1'b0));
      add_row(cmd_row(islf_pkg::CMD_PROPOSE, 16'h0001, 1'b0));
      add_row(cmd_row(islf_pkg::CMD_RECOMP, 16'h0000, 1'b0));
      // unusable settings: every command is a no-op with the error flag set
      add_row(cfg_row(9'd2, 3'd0));
      add_row(cmd_row(islf_pkg::CMD_RECOMP, 16'h0000, 1'b0));
      add_row(cfg_row(9'd1, 3'd1));
      add_row(cmd_row(islf_pkg::CMD_PROPOSE, 16'hFFFF, 1'b1));
      add_row(cfg_row(9'd256, 3'd4));
      add_row(cmd_row(islf_pkg::CMD_LOAD, 16'h0000, 1'b0));
      add_row(cfg_row(9'd511, 3'd7));
      add_row(cmd_row(CMD_SPARE_LO, 16'hFFFF, 1'b1));
      add_row(cfg_row(9'd0, 3'd5));
      add_row(cmd_row(islf_pkg::CMD_REJECT, 16'h0000, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_q[i]) begin
         if (table_q[i].is_cfg) set_lattice(table_q[i].side, table_q[i].dim);
         else send_word(table_q[i].cmd, table_q[i].site, table_q[i].spin,
                        table_q[i].typed, table_q[i].want);
      end

      // random phases over several lattice shapes
      set_lattice(9'd4, 3'd2);   fill_lattice(); random_words(60, 1);
      set_lattice(9'd2, 3'd4);   fill_lattice(); random_words(40, 1);
      set_lattice(9'd3, 3'd3);   fill_lattice(); random_words(40, 1);
      // full store and longest side: loads, decisions and spares only, no spin reads
      set_lattice(9'd16, 3'd4);  random_words(40, 0);
      set_lattice(9'd256, 3'd1); random_words(25, 0);
      set_lattice(9'd2, 3'd1);   fill_lattice(); random_words(30, 1);
      set_lattice(9'd5, 3'd2);   fill_lattice(); random_words(40, 1);

      // drain and settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_obs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
